>>> src/adc_round_robin_scanner_core_defines.svh
// assertion macros for the adc round-robin scanner
// expects clk and arst_n in the scope where a macro is used
`ifndef ADC_ROUND_ROBIN_SCANNER_CORE_DEFINES_SVH
`define ADC_ROUND_ROBIN_SCANNER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ADCRR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ADCRR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/adcrr_pkg.sv
// shared types and constants for the adc round-robin scanner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package adcrr_pkg;

	localparam int NUM_CHANNELS = 16;
	localparam int CH_W         = 4;
	localparam int SAMPLE_W     = 12;
	localparam int VALUE_W      = 13;

	// channel count at compare width
	localparam logic [CH_W:0] NUM_CH_CMP = (CH_W + 1)'(NUM_CHANNELS);

	// value answered for a channel that is not enabled
	localparam logic signed [VALUE_W-1:0] NOT_ENABLED = -13'sd1023;

	typedef enum logic [1:0] {
		FUNC_TICK   = 2'd0,
		FUNC_ENABLE = 2'd1,
		FUNC_READ   = 2'd2
	} func_t;

	// result of the next-enabled-channel search
	typedef struct packed {
		logic            found;
		logic [CH_W-1:0] ch;
	} pick_t;

endpackage

`default_nettype wire

>>> src/adcrr_req_if.sv
// request channel of the adc round-robin scanner
// depends on adcrr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface adcrr_req_if import adcrr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [1:0]          func;
	logic [CH_W-1:0]     channel;
	logic                adc_ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output func, output channel, output adc_ready,
		output sample, input ready);
	modport sink (input valid, input func, input channel, input adc_ready,
		input sample, output ready);
endinterface

`default_nettype wire

>>> src/adcrr_rsp_if.sv
// result channel of the adc round-robin scanner
// depends on adcrr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface adcrr_rsp_if import adcrr_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      start_conversion;
	logic [CH_W-1:0]           conversion_channel;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output start_conversion, output conversion_channel,
		output value, input ready);
	modport sink (input valid, input start_conversion, input conversion_channel,
		input value, output ready);
endinterface

`default_nettype wire

>>> src/adcrr_pick.sv
// next enabled channel search, round-robin from a start position
// depends on adcrr_pkg
`timescale 1ns / 1ps
`default_nettype none

module adcrr_pick import adcrr_pkg::*; (
	input  logic [NUM_CHANNELS-1:0] mask,
	input  logic [CH_W-1:0]         start,
	output pick_t                   pick
);

	logic [CH_W:0] base;

	// a start position beyond the channel count restarts at zero
	assign base = ({1'b0, start} >= NUM_CH_CMP) ? '0 : {1'b0, start};

	// priority over rotated positions, nearest one wins
	always_comb begin
		logic [CH_W:0] idx;
		pick = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			idx = base + (CH_W + 1)'(i);
			if (idx >= NUM_CH_CMP) begin
				idx = idx - NUM_CH_CMP;
			end
			if (mask[idx[CH_W-1:0]]) begin
				pick.found = 1'b1;
				pick.ch    = idx[CH_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

>>> src/adc_round_robin_scanner_core.sv
// Round-robin scheduler for a shared analog converter.
// Request channel (req): func, channel, adc_ready, sample. func selects a scan tick,
// a channel enable that also stores the first sample, or a read of a channel.
// Result channel (rsp): start_conversion, conversion_channel, value. Every request
// gives exactly one result; a read of a channel that is not enabled answers -1023.
// Each request passes an accept step and an execute step: the accept cycle reads the
// sample memory into a read register, the execute state updates the memory, the enable
// mask and the scan position and loads the result register. The request is captured in
// the s1 registers and the result in the output register, and no new request is taken
// until the execute state has ended.
// The result sits in an output register, so the next request is taken while that
// result is being handed off. If the receiver stalls, the result is held and no
// further request is taken until the receiver takes it.
// Reset clears the enable mask, the scan position, the pending flag and the result valid
// flag; the sample memory is not cleared, and an entry's value is only returned after an enable wrote it.
// depends on adcrr_pkg, adcrr_req_if, adcrr_rsp_if, adcrr_pick and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "adc_round_robin_scanner_core_defines.svh"

module adc_round_robin_scanner_core import adcrr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	adcrr_req_if.sink  req,
	adcrr_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;

	logic [SAMPLE_W-1:0] mem [NUM_CHANNELS];

	logic [NUM_CHANNELS-1:0] mask_q;
	logic [CH_W-1:0]         cur_q;
	logic                    pending_q;

	logic [1:0]          func_s1;
	logic [CH_W-1:0]     channel_s1;
	logic                adc_ready_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [SAMPLE_W-1:0] rd_s1;

	logic                      out_valid_q;
	logic                      out_start_q;
	logic [CH_W-1:0]           out_ch_q;
	logic signed [VALUE_W-1:0] out_value_q;

	logic                    accept;
	logic                    exec;
	logic [CH_W-1:0]         nxt_ch;
	logic                    tick_go;
	logic                    tick_store;
	logic [CH_W-1:0]         base_ch;
	pick_t                   pick;
	logic                    ch_ok;
	logic [NUM_CHANNELS-1:0] mask_bit;

	logic                      mem_we;
	logic [CH_W-1:0]           mem_waddr;
	logic [SAMPLE_W-1:0]       mem_wdata;
	logic                      res_start;
	logic [CH_W-1:0]           res_ch;
	logic signed [VALUE_W-1:0] res_value;
	logic                      set_mask;
	logic                      upd_scan;

	// request taken when idle and the result register is free or draining
	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign exec      = (state_q == ST_EXEC);

	// scan step helpers
	always_comb begin
		nxt_ch     = (cur_q == CH_W'(NUM_CHANNELS - 1)) ? '0 : cur_q + 1'b1;
		tick_store = pending_q && adc_ready_s1;
		tick_go    = !pending_q || adc_ready_s1;
		base_ch    = tick_store ? nxt_ch : cur_q;
		ch_ok      = ({1'b0, channel_s1} < NUM_CH_CMP);
		mask_bit   = '0;
		mask_bit[channel_s1] = 1'b1;
	end

	adcrr_pick u_pick (
		.mask  (mask_q),
		.start (base_ch),
		.pick  (pick)
	);

	// result and memory write of the item in flight
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = channel_s1;
		mem_wdata = sample_s1;
		res_start = 1'b0;
		res_ch    = '0;
		res_value = '0;
		set_mask  = 1'b0;
		upd_scan  = 1'b0;
		case (func_s1)
			FUNC_TICK: begin
				upd_scan = tick_go;
				if (tick_store) begin
					mem_we    = 1'b1;
					mem_waddr = cur_q;
				end
				if (tick_go && pick.found) begin
					res_start = 1'b1;
					res_ch    = pick.ch;
				end
			end
			FUNC_ENABLE: begin
				if (ch_ok) begin
					mem_we    = 1'b1;
					set_mask  = 1'b1;
					res_value = VALUE_W'($signed({1'b0, sample_s1}));
				end else begin
					res_value = NOT_ENABLED;
				end
			end
			FUNC_READ: begin
				if (ch_ok && mask_q[channel_s1]) begin
					res_value = VALUE_W'($signed({1'b0, rd_s1}));
				end else begin
					res_value = NOT_ENABLED;
				end
			end
			default: begin
				res_value = '0;
			end
		endcase
	end

	// sample memory, read at accept, written in the execute state
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[req.channel];
		end
		if (exec && mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	// capture of the accepted request
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1      <= req.func;
			channel_s1   <= req.channel;
			adc_ready_s1 <= req.adc_ready;
			sample_s1    <= req.sample;
		end
	end

	// sequencer and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mask_q    <= '0;
			cur_q     <= '0;
			pending_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					if (set_mask) begin
						mask_q <= mask_q | mask_bit;
					end
					if (upd_scan) begin
						pending_q <= pick.found;
						cur_q     <= pick.found ? pick.ch : base_ch;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_start_q <= res_start;
			out_ch_q    <= res_ch;
			out_value_q <= res_value;
		end
	end

	assign rsp.valid              = out_valid_q;
	assign rsp.start_conversion   = out_start_q;
	assign rsp.conversion_channel = out_ch_q;
	assign rsp.value              = out_value_q;

	// checks
	`ADCRR_ASSERT_NOW(a_pending_enabled, pending_q, mask_q[cur_q],
		"pending conversion on a channel that is not enabled")
	`ADCRR_ASSERT_NOW(a_start_enabled, rsp.valid && rsp.start_conversion,
		mask_q[rsp.conversion_channel] && rsp.value == '0,
		"start command for a disabled channel or with a nonzero value")
	`ADCRR_ASSERT_NEXT(a_accept_exec, accept, exec && !out_valid_q,
		"accepted request not followed by an execute cycle with a free result register")

endmodule

`default_nettype wire
